// ===== src/twips_pkg.sv =====
// ----------------------------------------------------------------------------
// twips_pkg
// Shared types and constants of the trie word insert / prefix search unit.
// ----------------------------------------------------------------------------
package twips_pkg;

   localparam int LETTER_W          = 5;
   localparam int MAX_NODES_DEFAULT = 1024;
   localparam int ALPHABET_DEFAULT  = 26;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [LETTER_W-1:0] letter;
      logic                first;
      logic                last;
   } req_payload_type;

   typedef struct packed {
      logic found;
      logic resolved;
      logic overflow;
   } rsp_payload_type;

endpackage

// ===== src/twips_chan_if.sv =====
// ----------------------------------------------------------------------------
// twips_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface twips_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/trie_word_insert_prefix_search_unit.sv =====
// ----------------------------------------------------------------------------
// trie_word_insert_prefix_search_unit
// Trie dictionary fed one letter per word: insert walks allocate nodes and
// mark word ends, search walks report a hit on the first word-end node.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its child-link memory, one entry per cycle, over
// all MAX_NODES * ALPHABET entries and holds req ready low meanwhile. After
// that each letter word takes two steps: the idle state reads the child link
// of the current node from the single link memory into a read register, and
// the exec state updates it, writes it back and loads the result register.
// A result waiting on rsp does not block the next letter from being taken; the
// exec step of that letter stalls until the result register frees up. Each
// link entry also carries the word-end mark of the child it points to, since
// every node has exactly one parent slot.
// ----------------------------------------------------------------------------
module trie_word_insert_prefix_search_unit #(
   parameter int MAX_NODES = twips_pkg::MAX_NODES_DEFAULT,
   parameter int ALPHABET  = twips_pkg::ALPHABET_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   twips_chan_if.sink   req_chan,
   twips_chan_if.source rsp_chan
);

   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int MEM_DEPTH = MAX_NODES * ALPHABET;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int ENTRY_W   = NODE_W + 1;

   // link memory: {child is word end, child node}
   logic [ENTRY_W-1:0] link_mem [MEM_DEPTH];
   logic [ENTRY_W-1:0] mem_rdata_ff;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   twips_pkg::state_type       state_ff, state_in;
   logic [ADDR_W-1:0]          clr_ff, clr_in;
   logic [NODE_W-1:0]          cursor_ff, cursor_in;
   logic                       done_ff, done_in;
   logic [NODE_W-1:0]          count_ff, count_in;
   twips_pkg::opcode_type      op_ff, op_in;
   logic                       last_ff, last_in;
   logic                       skip_ff, skip_in;
   logic                       bad_ff, bad_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   twips_pkg::rsp_payload_type rsp_ff, rsp_in;

   twips_pkg::req_payload_type req;
   logic                       req_accept;
   logic                       rsp_free;
   logic [NODE_W-1:0]          cur_eff;
   logic [31:0]                letter_ext;
   logic                       letter_bad;
   logic [NODE_W-1:0]          rd_link;
   logic                       rd_end;
   logic                       store_full;

   assign req        = req_chan.payload;
   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign cur_eff    = req.first ? '0 : cursor_ff;
   assign letter_ext = 32'(req.letter);
   assign letter_bad = letter_ext >= 32'(ALPHABET);
   assign mem_raddr  = ADDR_W'(cur_eff) * ADDR_W'(ALPHABET) + ADDR_W'(req.letter);
   assign rd_link    = mem_rdata_ff[NODE_W-1:0];
   assign rd_end     = mem_rdata_ff[NODE_W];
   assign store_full = count_ff == NODE_W'(MAX_NODES - 1);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= link_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twips_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         done_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         done_ff      <= done_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      last_ff <= last_in;
      skip_ff <= skip_in;
      bad_ff  <= bad_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cursor_in    = cursor_ff;
      done_in      = done_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      skip_in      = skip_ff;
      bad_in       = bad_ff;
      addr_in      = addr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      req_chan.ready = 1'b0;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;

      unique case (state_ff)
         twips_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = twips_pkg::ST_IDLE;
            end
         end

         twips_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_accept) begin
               // restart the walk here so the read uses the right row
               cursor_in = cur_eff;
               done_in   = req.first ? 1'b0 : done_ff;
               op_in     = req.opcode;
               last_in   = req.last;
               skip_in   = req.first ? 1'b0 : done_ff;
               bad_in    = letter_bad;
               addr_in   = mem_raddr;
               mem_re    = !letter_bad;
               state_in  = twips_pkg::ST_EXEC;
            end
         end

         twips_pkg::ST_EXEC: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = twips_pkg::ST_IDLE;
               if (skip_ff) begin
                  // walk already finished: answer with all zero
               end else if (bad_ff) begin
                  done_in         = 1'b1;
                  rsp_in.resolved = (op_ff == twips_pkg::OP_SEARCH);
               end else if (op_ff == twips_pkg::OP_INSERT) begin
                  if (rd_link == '0) begin
                     if (store_full) begin
                        rsp_in.overflow = 1'b1;
                        done_in         = 1'b1;
                     end else begin
                        // allocate the next free node
                        count_in  = count_ff + 1'b1;
                        cursor_in = count_ff + 1'b1;
                        mem_we    = 1'b1;
                        mem_wdata = {last_ff, count_ff + 1'b1};
                        done_in   = last_ff;
                     end
                  end else begin
                     cursor_in = rd_link;
                     if (last_ff) begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, rd_link};
                        done_in   = 1'b1;
                     end
                  end
               end else begin
                  if (rd_link == '0) begin
                     rsp_in.resolved = 1'b1;
                     done_in         = 1'b1;
                  end else begin
                     cursor_in = rd_link;
                     if (rd_end) begin
                        rsp_in.found    = 1'b1;
                        rsp_in.resolved = 1'b1;
                        done_in         = 1'b1;
                     end else if (last_ff) begin
                        rsp_in.resolved = 1'b1;
                        done_in         = 1'b1;
                     end
                  end
               end
            end
         end

         default: begin
            state_in = twips_pkg::ST_CLEAR;
         end
      endcase
   end

   a_overflow_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == twips_pkg::ST_EXEC && rsp_free && rsp_in.overflow) |-> store_full)
      else $error("overflow reported with free nodes left");

   a_found_is_resolved: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> rsp_ff.resolved)
      else $error("found without resolved");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != twips_pkg::ST_CLEAR) |=> (count_ff >= $past(count_ff)))
      else $error("node count went down");

   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == twips_pkg::ST_EXEC))
      else $error("accepted word did not start its update cycle");

   a_no_write_in_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == twips_pkg::ST_IDLE) |-> !mem_we)
      else $error("link memory written while idle");

endmodule
